// ===== rtl/core/qd_pkg.sv =====
// shared constants, types and register indexes for the x4 quadrature decoder
// no dependencies; imported by every module of the block
package qd_pkg;

    localparam int TIMER_W    = 20;
    localparam int DET_W      = 8;
    localparam int REV_W      = 15;
    localparam int POS_W      = 16;
    localparam int STEP_W     = $clog2(POS_W);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_W    = $clog2(Q_DEPTH);
    localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] REG_LOCKOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DETENT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REV     = 2'd2;

    localparam logic [TIMER_W-1:0] TIMER_MAX     = '1;
    localparam logic [TIMER_W-1:0] LOCKOUT_RESET = 20'd1000;
    localparam logic [DET_W-1:0]   DETENT_RESET  = 8'd4;
    localparam logic [REV_W-1:0]   REV_RESET     = 15'd96;

    // pin pair codes, a in bit 1 and b in bit 0
    localparam logic [1:0] PINS_NONE = 2'b00;
    localparam logic [1:0] PINS_BOTH = 2'b11;

    typedef logic signed [POS_W-1:0] pos_t;

    typedef struct packed {
        logic [TIMER_W-1:0] lockout_ticks;
        logic [DET_W-1:0]   counts_per_detent;
        logic [REV_W-1:0]   counts_per_rev;
    } cfg_t;

endpackage

// ===== rtl/core/qd_front.sv =====
// front end: pin tracking, edge timer, lockout and up/down count
// depends on qd_pkg; pushes each tick's position into qd_fifo
module qd_front import qd_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  logic  pin_a,
    input  logic  pin_b,
    input  logic  clear_count,
    input  cfg_t  cfg,
    input  logic  q_full,
    output logic  push,
    output pos_t  push_data
);

    logic               primed_reg, primed_next;
    logic [1:0]         last_pins_reg, last_pins_next;
    logic [1:0]         acc_state_reg, acc_state_next;
    logic [TIMER_W-1:0] timer_reg, timer_next;
    logic               running_reg, running_next;
    pos_t               count_reg, count_next;

    logic [1:0]         pins;
    logic [1:0]         diff;
    logic [TIMER_W-1:0] timer_inc;
    logic [TIMER_W-1:0] elapsed;

    assign in_ready = !q_full;
    assign push     = in_valid && !q_full;
    assign pins     = {pin_a, pin_b};
    assign diff     = pins ^ acc_state_reg;
    assign timer_inc = (running_reg && timer_reg != TIMER_MAX) ? timer_reg + 1'b1 : timer_reg;
    assign elapsed  = running_reg ? timer_inc : '0;

    always_comb begin
        primed_next    = primed_reg;
        last_pins_next = last_pins_reg;
        acc_state_next = acc_state_reg;
        timer_next     = timer_reg;
        running_next   = running_reg;
        count_next     = count_reg;
        if (!primed_reg) begin
            primed_next    = 1'b1;
            last_pins_next = pins;
            acc_state_next = pins;
        end else begin
            timer_next = timer_inc;
            if (pins != last_pins_reg) begin
                timer_next   = '0;
                running_next = 1'b1;
                if (elapsed >= cfg.lockout_ticks) begin
                    // only a single-bit gray step moves the count
                    if (diff != PINS_BOTH && diff != PINS_NONE) begin
                        if (acc_state_reg[0] ^ pins[1]) begin
                            count_next = count_reg + 1'b1;
                        end else begin
                            count_next = count_reg - 1'b1;
                        end
                    end
                    acc_state_next = pins;
                end
            end
            last_pins_next = pins;
        end
        if (clear_count) begin
            count_next = '0;
        end
    end

    assign push_data = count_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            primed_reg    <= 1'b0;
            last_pins_reg <= '0;
            acc_state_reg <= '0;
            timer_reg     <= '0;
            running_reg   <= 1'b0;
            count_reg     <= '0;
        end else if (push) begin
            primed_reg    <= primed_next;
            last_pins_reg <= last_pins_next;
            acc_state_reg <= acc_state_next;
            timer_reg     <= timer_next;
            running_reg   <= running_next;
            count_reg     <= count_next;
        end
    end

endmodule

// ===== rtl/core/qd_fifo.sv =====
// short position queue between the front end and the divider
// depends on qd_pkg
module qd_fifo import qd_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  pos_t  push_data,
    input  logic  pop,
    output pos_t  pop_data,
    output logic  full,
    output logic  not_empty
);

    pos_t               mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [Q_CNT_W-1:0] cnt_reg;

    assign full      = cnt_reg == Q_CNT_W'(Q_DEPTH);
    assign not_empty = cnt_reg != '0;
    assign pop_data  = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/qd_div.sv =====
// back end: two bit-serial restoring dividers that share one dividend
// depends on qd_pkg; holds the result word until the sink takes it
module qd_div import qd_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  q_not_empty,
    output logic  pop,
    input  pos_t  pop_data,
    input  cfg_t  cfg,
    output logic  out_valid,
    input  logic  out_ready,
    output pos_t  out_position,
    output pos_t  out_detents,
    output pos_t  out_revolutions
);

    logic              busy_reg;
    logic [STEP_W-1:0] step_reg;
    logic              neg_reg;
    pos_t              pos_reg;
    logic [POS_W-1:0]  num_reg;
    logic [DET_W-1:0]  rem_det_reg;
    logic [REV_W-1:0]  rem_rev_reg;
    logic [POS_W-1:0]  q_det_reg, q_rev_reg;
    logic              out_valid_reg;
    pos_t              out_pos_reg, out_det_reg, out_rev_reg;

    logic [DET_W:0]    shift_det, sub_det;
    logic [REV_W:0]    shift_rev, sub_rev;
    logic              ge_det, ge_rev;
    logic [POS_W-1:0]  q_det_next, q_rev_next;
    logic [POS_W-1:0]  mag;
    logic              last_step, out_free, advance;
    pos_t              det_final, rev_final;

    assign mag = pop_data[POS_W-1] ? POS_W'(-pop_data) : POS_W'(pop_data);

    assign shift_det  = {rem_det_reg, num_reg[POS_W-1]};
    assign shift_rev  = {rem_rev_reg, num_reg[POS_W-1]};
    assign sub_det    = shift_det - {1'b0, cfg.counts_per_detent};
    assign sub_rev    = shift_rev - {1'b0, cfg.counts_per_rev};
    assign ge_det     = shift_det >= {1'b0, cfg.counts_per_detent};
    assign ge_rev     = shift_rev >= {1'b0, cfg.counts_per_rev};
    assign q_det_next = {q_det_reg[POS_W-2:0], ge_det};
    assign q_rev_next = {q_rev_reg[POS_W-2:0], ge_rev};

    assign last_step = step_reg == STEP_W'(POS_W - 1);
    assign out_free  = !out_valid_reg || out_ready;
    assign advance   = busy_reg && (!last_step || out_free);
    assign pop       = !busy_reg && q_not_empty;

    // zero divisor reads as quotient zero
    always_comb begin
        if (cfg.counts_per_detent == '0) begin
            det_final = '0;
        end else if (neg_reg) begin
            det_final = -q_det_next;
        end else begin
            det_final = q_det_next;
        end
        if (cfg.counts_per_rev == '0) begin
            rev_final = '0;
        end else if (neg_reg) begin
            rev_final = -q_rev_next;
        end else begin
            rev_final = q_rev_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            pos_reg     <= pop_data;
            neg_reg     <= pop_data[POS_W-1];
            num_reg     <= mag;
            rem_det_reg <= '0;
            rem_rev_reg <= '0;
            q_det_reg   <= '0;
            q_rev_reg   <= '0;
        end else if (advance) begin
            num_reg     <= {num_reg[POS_W-2:0], 1'b0};
            rem_det_reg <= ge_det ? sub_det[DET_W-1:0] : shift_det[DET_W-1:0];
            rem_rev_reg <= ge_rev ? sub_rev[REV_W-1:0] : shift_rev[REV_W-1:0];
            q_det_reg   <= q_det_next;
            q_rev_reg   <= q_rev_next;
        end
        if (advance && last_step) begin
            out_pos_reg <= pos_reg;
            out_det_reg <= det_final;
            out_rev_reg <= rev_final;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (advance) begin
                step_reg <= step_reg + 1'b1;
                if (last_step) begin
                    busy_reg <= 1'b0;
                end
            end
            if (advance && last_step) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_position    = out_pos_reg;
    assign out_detents     = out_det_reg;
    assign out_revolutions = out_rev_reg;

endmodule

// ===== rtl/core/quadrature_decoder_x4_lockout.sv =====
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  s_tdata[7:0]  pin_a, pin_b, clear_count
// m_*       out  m_tvalid/m_tready  m_tdata[47:0] position, detents, revolutions
// cfg_*     in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// the front end takes one tick word per cycle while the two-entry queue has room
// the divider loads each word, then forms its 16-bit quotients bit by bit; it takes
// no new word until the last bit is done, so the bit-serial divider sets the sustained rate
// a stalled sink holds the last quotient bit; the queue then fills and s_tready drops
// aresetn is synchronous; it clears all tracking state and restores register defaults
// depends on qd_pkg, qd_front, qd_fifo, qd_div
module quadrature_decoder_x4_lockout import qd_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // pin_a, pin_b, clear_count, zero pad
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [47:0]           m_tdata,   // position, detents, revolutions
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t  cfg_reg;
    logic  q_full, q_not_empty, push, pop;
    pos_t  push_data, pop_data;
    pos_t  position, detents, revolutions;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.lockout_ticks     <= LOCKOUT_RESET;
            cfg_reg.counts_per_detent <= DETENT_RESET;
            cfg_reg.counts_per_rev    <= REV_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_LOCKOUT: cfg_reg.lockout_ticks     <= cfg_data[TIMER_W-1:0];
                REG_DETENT:  cfg_reg.counts_per_detent <= cfg_data[DET_W-1:0];
                REG_REV:     cfg_reg.counts_per_rev    <= cfg_data[REV_W-1:0];
                default: begin
                end
            endcase
        end
    end

    qd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .pin_a       (s_tdata[0]),
        .pin_b       (s_tdata[1]),
        .clear_count (s_tdata[2]),
        .cfg         (cfg_reg),
        .q_full      (q_full),
        .push        (push),
        .push_data   (push_data)
    );

    qd_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .full      (q_full),
        .not_empty (q_not_empty)
    );

    qd_div u_div (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_not_empty     (q_not_empty),
        .pop             (pop),
        .pop_data        (pop_data),
        .cfg             (cfg_reg),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .out_position    (position),
        .out_detents     (detents),
        .out_revolutions (revolutions)
    );

    assign m_tdata = {revolutions, detents, position};

    // nothing comes out the cycle after reset
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // a zero position divides to zero on both quotients
    a_zero_quot: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && position == '0) |-> (detents == '0 && revolutions == '0))
        else $error("nonzero quotient of zero position");

    // unit detent divisor passes the position through, sign included
    a_unit_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && cfg_reg.counts_per_detent == DET_W'(1)) |-> detents == position)
        else $error("detents differ from position with unit divisor");

    // input stalls only because the queue is full
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> q_full)
        else $error("input stalled with room in the queue");

endmodule
